/* sv/aapc_pkg.sv */
// Shared types, widths, constants and the arctangent table of the arc coverage block.
package aapc_pkg;

  localparam int COORD_BITS_DEF   = 12;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int PXW  = 12;  // pixel coordinate port width
  localparam int CXW  = 14;  // centre register width
  localparam int DXW  = 16;  // signed pixel offset from the centre
  localparam int CW   = 34;  // CORDIC x and y datapath
  localparam int ZW   = 30;  // signed CORDIC angle accumulator
  localparam int AW   = 29;  // normalised angle, 2^20 per degree
  localparam int D2W  = 31;  // squared distance
  localparam int SQW  = 25;  // squared radius terms
  localparam int RNGW = 14;  // ramp numerator and range
  localparam int QW   = 9;   // ramp quotient, 0 to 256
  localparam int DIV_CELLS = 9;
  localparam int DIST_LAT  = 14;  // request edges to registered coverage alpha
  localparam int ATAN_LEN  = 24;

  localparam logic [ZW-1:0] ANG_90   = ZW'(90 * 1048576);
  localparam logic [ZW-1:0] ANG_180  = ZW'(180 * 1048576);
  localparam logic [ZW-1:0] ANG_270  = ZW'(270 * 1048576);
  localparam logic [ZW-1:0] ANG_FULL = ZW'(360 * 1048576);

  localparam logic [31:0] ARGB_ALPHA_MASK = 32'hFF000000;
  localparam logic [31:0] ARGB_RGB_MASK   = 32'h00FFFFFF;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_RADIUS      = 3'd2;
  localparam logic [2:0] REG_RING_WIDTH  = 3'd3;
  localparam logic [2:0] REG_START_ANGLE = 3'd4;
  localparam logic [2:0] REG_END_ANGLE   = 3'd5;
  localparam logic [2:0] REG_COLOR       = 3'd6;
  localparam logic [2:0] REG_FILL_MODE   = 3'd7;

  typedef enum logic [1:0] {
    WK_SKIP  = 2'd0,
    WK_WRITE = 2'd1,
    WK_BLEND = 2'd2
  } wkind_t;

  // How the distance test covers a pixel.
  typedef enum logic [1:0] {
    CV_NONE = 2'd0,
    CV_FULL = 2'd1,
    CV_RAMP = 2'd2
  } cov_t;

  // Exact axis angles bypass the CORDIC result.
  typedef enum logic [1:0] {
    AX_0   = 2'd0,
    AX_90  = 2'd1,
    AX_180 = 2'd2,
    AX_270 = 2'd3
  } axis_t;

  typedef struct packed {
    logic  on_axis;
    axis_t axis;
  } ang_tag_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = ZW'(47185920);
      1:  v = ZW'(27855475);
      2:  v = ZW'(14718068);
      3:  v = ZW'(7471121);
      4:  v = ZW'(3750058);
      5:  v = ZW'(1876857);
      6:  v = ZW'(938658);
      7:  v = ZW'(469357);
      8:  v = ZW'(234682);
      9:  v = ZW'(117342);
      10: v = ZW'(58671);
      11: v = ZW'(29335);
      12: v = ZW'(14668);
      13: v = ZW'(7334);
      14: v = ZW'(3667);
      15: v = ZW'(1833);
      16: v = ZW'(917);
      17: v = ZW'(458);
      18: v = ZW'(229);
      19: v = ZW'(115);
      20: v = ZW'(57);
      21: v = ZW'(29);
      22: v = ZW'(14);
      23: v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/aapc_cordic_cell.sv */
// One vectoring CORDIC step with its own output registers.
module aapc_cordic_cell
  import aapc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  ang_tag_t             tag_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output ang_tag_t             tag_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_entry(STEP);

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  ang_tag_t             tag_r;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (y_i > 0) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= tag_i;
    end
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign tag_o = tag_r;

endmodule

/* sv/aapc_div_cell.sv */
// One restoring division step producing one quotient bit of the edge ramp.
module aapc_div_cell
  import aapc_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [RNGW-1:0] rem_i,
  input  logic [RNGW-1:0] rng_i,
  input  logic [QW-1:0]   q_i,
  input  cov_t            kind_i,
  output logic [RNGW-1:0] rem_o,
  output logic [RNGW-1:0] rng_o,
  output logic [QW-1:0]   q_o,
  output cov_t            kind_o
);

  logic [RNGW:0]   cmp;
  logic            ge;
  logic [RNGW-1:0] rem_r, rem_nxt, rng_r;
  logic [QW-1:0]   q_r, q_nxt;
  cov_t            kind_r;

  // The remainder stays below the range, so the trial value fits one extra bit.
  always_comb begin
    cmp     = FIRST ? {1'b0, rem_i} : {rem_i, 1'b0};
    ge      = cmp >= {1'b0, rng_i};
    rem_nxt = ge ? RNGW'(cmp - {1'b0, rng_i}) : RNGW'(cmp);
    q_nxt   = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      rng_r  <= rng_i;
      q_r    <= q_nxt;
      kind_r <= kind_i;
    end
  end

  assign rem_o  = rem_r;
  assign rng_o  = rng_r;
  assign q_o    = q_r;
  assign kind_o = kind_r;

endmodule

/* sv/aapc_delay.sv */
// Enabled shift register that aligns the two pipeline branches.
module aapc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  assign d_o = sh_r[DEPTH-1];

endmodule

/* sv/antialiased_arc_pixel_coverage_top.sv */
// Top level of the anti-aliased arc and filled-sector pixel coverage pipeline.
//
//  Channel  Ports                                        Direction  Moves
//  -------  -------------------------------------------  ---------  -------------------------
//  in       in_valid, in_stall, in_pixel_x, in_pixel_y   into block one pixel request
//  out      out_valid, out_stall, out_x, out_y,          out of     one coverage result
//           out_write_kind, out_alpha, out_pixel_argb
//  cfg      cfg_wr_en, cfg_index, cfg_data               into block one register write
//
// One request is taken every clock cycle while in_stall is low. The latency is set by
// the row of CORDIC cells (one cell per step) or, for short rows, by the nine-cell ramp
// divider.
// Reset is synchronous, returns the configuration registers to their defaults and
// clears every stage valid bit; there is no clearing pass, so a request may be offered
// in the first cycle after reset.
// A stall on the result side freezes the whole chain; in_stall is raised only while
// the output register holds a result that is itself stalled.
module antialiased_arc_pixel_coverage_top
  import aapc_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [PXW-1:0]  in_pixel_x,
  input  logic [PXW-1:0]  in_pixel_y,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PXW-1:0]  out_x,
  output logic [PXW-1:0]  out_y,
  output logic [1:0]      out_write_kind,
  output logic [7:0]      out_alpha,
  output logic [31:0]     out_pixel_argb,
  input  logic            cfg_wr_en,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int NSTEP   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int ANG_LAT = NSTEP + 3;
  localparam int LAT     = ((DIST_LAT > ANG_LAT) ? DIST_LAT : ANG_LAT) + 1;
  localparam logic [PXW-1:0] CMASK = PXW'((64'd1 << COORD_BITS) - 64'd1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Change them only while the pipeline is empty (unchecked).
  // ---------------------------------------------------------------------------
  logic signed [CXW-1:0] cx_r, cy_r;
  logic [11:0]           radius_r;
  logic [10:0]           ring_w_r;
  logic [12:0]           start_r, end_r;
  logic [31:0]           color_r;
  logic                  fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      radius_r <= '0;
      ring_w_r <= 11'd1;
      start_r  <= '0;
      end_r    <= 13'd5760;
      color_r  <= 32'hFFFFFFFF;
      fill_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CENTER_X:    cx_r     <= cfg_data[CXW-1:0];
        REG_CENTER_Y:    cy_r     <= cfg_data[CXW-1:0];
        REG_RADIUS:      radius_r <= cfg_data[11:0];
        REG_RING_WIDTH:  ring_w_r <= cfg_data[10:0];
        REG_START_ANGLE: start_r  <= cfg_data[12:0];
        REG_END_ANGLE:   end_r    <= cfg_data[12:0];
        REG_COLOR:       color_r  <= cfg_data;
        REG_FILL_MODE:   fill_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Radius-derived thresholds, recomputed every cycle from the registers. A
  // request reaches the classification stage after the stage-1 and distance
  // registers, by which time these have caught up with any preceding register write.
  // ---------------------------------------------------------------------------
  logic [11:0]     rw_c, ir_c;
  logic [23:0]     o2_c, i2_c;
  logic [SQW-1:0]  o2_nxt, oaa_nxt, i2_nxt, iaa_nxt, rin_nxt;
  logic [SQW-1:0]  o2_r, oaa_r, i2_r, iaa_r, rin_r;
  logic [RNGW-1:0] rng_out_nxt, rng_in_nxt, rng_fill_nxt;
  logic [RNGW-1:0] rng_out_r, rng_in_r, rng_fill_r;
  logic            ring_en_nxt, ring_en_r, r_pos_nxt, r_pos_r;

  always_comb begin
    rw_c    = ({1'b0, ring_w_r} > (radius_r >> 1)) ? (radius_r >> 1) : {1'b0, ring_w_r};
    ir_c    = radius_r - rw_c;
    o2_c    = radius_r * radius_r;
    i2_c    = ir_c * ir_c;
    o2_nxt  = SQW'(o2_c);
    oaa_nxt = SQW'(o2_c) + SQW'({radius_r, 1'b0});
    i2_nxt  = SQW'(i2_c);
    // (ir-1)^2 is ir^2 - 2ir + 1, and (r-1)^2 likewise.
    iaa_nxt = (ir_c != '0) ? SQW'(i2_c) - SQW'({ir_c, 1'b0}) + SQW'(1) : '0;
    rin_nxt = (radius_r > 12'd1) ? SQW'(o2_c) - SQW'({radius_r, 1'b0}) + SQW'(1) : '0;
    rng_out_nxt  = RNGW'({radius_r, 1'b0});
    rng_in_nxt   = (ir_c != '0) ? RNGW'({ir_c, 1'b0}) - RNGW'(1) : '0;
    rng_fill_nxt = RNGW'({radius_r, 2'b00}) - RNGW'(1);
    r_pos_nxt    = radius_r != '0;
    ring_en_nxt  = (radius_r != '0) && (ring_w_r != '0);
  end

  always_ff @(posedge clk) begin
    o2_r       <= o2_nxt;
    oaa_r      <= oaa_nxt;
    i2_r       <= i2_nxt;
    iaa_r      <= iaa_nxt;
    rin_r      <= rin_nxt;
    rng_out_r  <= rng_out_nxt;
    rng_in_r   <= rng_in_nxt;
    rng_fill_r <= rng_fill_nxt;
    r_pos_r    <= r_pos_nxt;
    ring_en_r  <= ring_en_nxt;
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage moves together whenever the output register can
  // take a new value.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  logic [LAT-1:0] vld_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: mask the coordinates and form the offset from the centre.
  // ---------------------------------------------------------------------------
  logic [PXW-1:0]        px1_r, py1_r, px_m, py_m;
  logic signed [DXW-1:0] dx1_r, dy1_r, dx_nxt, dy_nxt;

  always_comb begin
    px_m   = in_pixel_x & CMASK;
    py_m   = in_pixel_y & CMASK;
    dx_nxt = $signed({{(DXW-PXW){1'b0}}, px_m}) - $signed({{(DXW-CXW){cx_r[CXW-1]}}, cx_r});
    dy_nxt = $signed({{(DXW-PXW){1'b0}}, py_m}) - $signed({{(DXW-CXW){cy_r[CXW-1]}}, cy_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= px_m;
      py1_r <= py_m;
      dx1_r <= dx_nxt;
      dy1_r <= dy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Angle branch. The vertical axis points up, so the CORDIC sees -dy. Vectors
  // in the left half plane are first turned by a quarter turn; axis pixels take
  // an exact angle that is carried alongside the cells.
  // ---------------------------------------------------------------------------
  logic signed [DXW-1:0] up_c;
  logic signed [CW-1:0]  xw_c, uw_c;
  logic signed [CW-1:0]  x0_nxt, y0_nxt;
  logic signed [ZW-1:0]  z0_nxt;
  ang_tag_t              tag0_nxt;

  logic signed [CW-1:0]  xc [NSTEP+1];
  logic signed [CW-1:0]  yc [NSTEP+1];
  logic signed [ZW-1:0]  zc [NSTEP+1];
  ang_tag_t              tc [NSTEP+1];

  always_comb begin
    up_c = -dy1_r;
    xw_c = {{(CW-DXW){dx1_r[DXW-1]}}, dx1_r} <<< 16;
    uw_c = {{(CW-DXW){up_c[DXW-1]}}, up_c} <<< 16;
    x0_nxt = xw_c;
    y0_nxt = uw_c;
    z0_nxt = '0;
    if (dx1_r < 0) begin
      if (up_c >= 0) begin
        x0_nxt = uw_c;
        y0_nxt = -xw_c;
        z0_nxt = ANG_90;
      end else begin
        x0_nxt = -uw_c;
        y0_nxt = xw_c;
        z0_nxt = -ANG_90;
      end
    end
    tag0_nxt.on_axis = (up_c == 0) || (dx1_r == 0);
    if (up_c == 0) begin
      tag0_nxt.axis = (dx1_r >= 0) ? AX_0 : AX_180;
    end else begin
      tag0_nxt.axis = (up_c > 0) ? AX_90 : AX_270;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xc[0] <= x0_nxt;
      yc[0] <= y0_nxt;
      zc[0] <= z0_nxt;
      tc[0] <= tag0_nxt;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_cordic
    aapc_cordic_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_i   (xc[k]),
      .y_i   (yc[k]),
      .z_i   (zc[k]),
      .tag_i (tc[k]),
      .x_o   (xc[k+1]),
      .y_o   (yc[k+1]),
      .z_o   (zc[k+1]),
      .tag_o (tc[k+1])
    );
  end

  // Normalise into one turn and test against the angle window, which wraps
  // through zero when the end lies below the start.
  logic [AW-1:0] ang_c, s_ang_c, e_ang_c;
  logic          inr_nxt, inr_r, inr_d;

  always_comb begin
    if (tc[NSTEP].on_axis) begin
      case (tc[NSTEP].axis)
        AX_0:    ang_c = '0;
        AX_90:   ang_c = AW'(ANG_90);
        AX_180:  ang_c = AW'(ANG_180);
        AX_270:  ang_c = AW'(ANG_270);
        default: ang_c = '0;
      endcase
    end else if (zc[NSTEP] < 0) begin
      ang_c = AW'(zc[NSTEP] + $signed(ANG_FULL));
    end else begin
      ang_c = AW'(zc[NSTEP]);
    end
    s_ang_c = {start_r, 16'd0};
    e_ang_c = {end_r, 16'd0};
    if (start_r <= end_r) begin
      inr_nxt = (ang_c >= s_ang_c) && (ang_c <= e_ang_c);
    end else begin
      inr_nxt = (ang_c >= s_ang_c) || (ang_c <= e_ang_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr_r <= inr_nxt;
    end
  end

  aapc_delay #(.W(1), .DEPTH(LAT - ANG_LAT)) u_inr_dly (
    .clk (clk),
    .en  (en),
    .d_i (inr_r),
    .d_o (inr_d)
  );

  // ---------------------------------------------------------------------------
  // Distance branch: squared distance, then classification against the outer
  // and inner soft edges, then a ramp through the divider cells.
  // ---------------------------------------------------------------------------
  logic signed [2*DXW-1:0] dxsq_c, dysq_c;
  logic [D2W-1:0]          d2_r;

  always_comb begin
    dxsq_c = dx1_r * dx1_r;
    dysq_c = dy1_r * dy1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r <= D2W'(dxsq_c) + D2W'(dysq_c);
    end
  end

  logic [D2W-1:0]  o2_w, oaa_w, i2_w, iaa_w, rin_w;
  cov_t            cls_kind_nxt, cls_kind_r;
  logic [RNGW-1:0] cls_num_nxt, cls_num_r, cls_rng_nxt, cls_rng_r;

  always_comb begin
    o2_w  = D2W'(o2_r);
    oaa_w = D2W'(oaa_r);
    i2_w  = D2W'(i2_r);
    iaa_w = D2W'(iaa_r);
    rin_w = D2W'(rin_r);
    cls_kind_nxt = CV_NONE;
    cls_num_nxt  = '0;
    cls_rng_nxt  = '0;
    if (!fill_r) begin
      if (ring_en_r && (d2_r <= oaa_w) && (d2_r >= iaa_w)) begin
        if (d2_r >= o2_w) begin
          cls_kind_nxt = CV_RAMP;
          cls_num_nxt  = RNGW'(oaa_w - d2_r);
          cls_rng_nxt  = rng_out_r;
        end else if (d2_r <= i2_w) begin
          if (rng_in_r != '0) begin
            cls_kind_nxt = CV_RAMP;
            cls_num_nxt  = RNGW'(d2_r - iaa_w);
            cls_rng_nxt  = rng_in_r;
          end
        end else begin
          cls_kind_nxt = CV_FULL;
        end
      end
    end else if (r_pos_r && (d2_r <= oaa_w)) begin
      if (d2_r <= rin_w) begin
        cls_kind_nxt = CV_FULL;
      end else begin
        cls_kind_nxt = CV_RAMP;
        cls_num_nxt  = RNGW'(oaa_w - d2_r);
        cls_rng_nxt  = rng_fill_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_kind_r <= cls_kind_nxt;
      cls_num_r  <= cls_num_nxt;
      cls_rng_r  <= cls_rng_nxt;
    end
  end

  // The quotient num * 256 / range never exceeds 256, since num <= range.
  logic [RNGW-1:0] drem [DIV_CELLS+1];
  logic [RNGW-1:0] drng [DIV_CELLS+1];
  logic [QW-1:0]   dq   [DIV_CELLS+1];
  cov_t            dk   [DIV_CELLS+1];

  assign drem[0] = cls_num_r;
  assign drng[0] = cls_rng_r;
  assign dq[0]   = '0;
  assign dk[0]   = cls_kind_r;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    aapc_div_cell #(.FIRST(k == 0)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (drem[k]),
      .rng_i  (drng[k]),
      .q_i    (dq[k]),
      .kind_i (dk[k]),
      .rem_o  (drem[k+1]),
      .rng_o  (drng[k+1]),
      .q_o    (dq[k+1]),
      .kind_o (dk[k+1])
    );
  end

  // Squared ramp, then scaled by the foreground alpha.
  logic [2*QW-1:0] tsq_c;
  logic [QW-1:0]   sm_r;
  cov_t            sm_kind_r;
  logic [7:0]      fg_c;
  logic [16:0]     fgm_c;
  logic [7:0]      alpha_r, alpha_nxt, alpha_d;

  assign tsq_c = dq[DIV_CELLS] * dq[DIV_CELLS];

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r      <= tsq_c[16:8];
      sm_kind_r <= dk[DIV_CELLS];
    end
  end

  always_comb begin
    fg_c  = color_r[31:24];
    fgm_c = fg_c * sm_r;
    case (sm_kind_r)
      CV_FULL: alpha_nxt = fg_c;
      CV_RAMP: alpha_nxt = fgm_c[15:8];
      default: alpha_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= alpha_nxt;
    end
  end

  aapc_delay #(.W(8), .DEPTH(LAT - DIST_LAT)) u_alpha_dly (
    .clk (clk),
    .en  (en),
    .d_i (alpha_r),
    .d_o (alpha_d)
  );

  logic [2*PXW-1:0] xy_d;

  aapc_delay #(.W(2*PXW), .DEPTH(LAT - 1)) u_xy_dly (
    .clk (clk),
    .en  (en),
    .d_i ({px1_r, py1_r}),
    .d_o (xy_d)
  );

  // ---------------------------------------------------------------------------
  // Output register: pick skip, overwrite or blend from the final alpha.
  // ---------------------------------------------------------------------------
  logic [7:0]      a_fin;
  wkind_t          kind_nxt, kind_r;
  logic [7:0]      alpha_o_nxt, alpha_o_r;
  logic [31:0]     argb_nxt, argb_r;
  logic [PXW-1:0]  ox_r, oy_r;

  always_comb begin
    a_fin = inr_d ? alpha_d : '0;
    if (a_fin == '0) begin
      kind_nxt    = WK_SKIP;
      alpha_o_nxt = '0;
      argb_nxt    = '0;
    end else if (a_fin == 8'hFF) begin
      kind_nxt    = WK_WRITE;
      alpha_o_nxt = 8'hFF;
      argb_nxt    = (color_r & ARGB_RGB_MASK) | ARGB_ALPHA_MASK;
    end else begin
      kind_nxt    = WK_BLEND;
      alpha_o_nxt = a_fin;
      argb_nxt    = color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r    <= kind_nxt;
      alpha_o_r <= alpha_o_nxt;
      argb_r    <= argb_nxt;
      ox_r      <= xy_d[2*PXW-1:PXW];
      oy_r      <= xy_d[PXW-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = ox_r;
  assign out_y          = oy_r;
  assign out_write_kind = kind_r;
  assign out_alpha      = alpha_o_r;
  assign out_pixel_argb = argb_r;

  // ---------------------------------------------------------------------------
  // Checks on the result encoding.
  // ---------------------------------------------------------------------------
  a_skip_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_write_kind == WK_SKIP) |-> (out_alpha == '0) && (out_pixel_argb == '0))
    else $error("skip result carries alpha or colour");

  a_write_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_write_kind == WK_WRITE) |->
      (out_alpha == 8'hFF) && (out_pixel_argb[31:24] == 8'hFF))
    else $error("overwrite result is not opaque");

  a_blend_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_write_kind == WK_BLEND) |-> (out_alpha != '0) && (out_alpha != 8'hFF))
    else $error("blend result has a trivial alpha");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_kind == WK_SKIP) || (out_write_kind == WK_WRITE) ||
                  (out_write_kind == WK_BLEND))
    else $error("result kind out of range");

endmodule
